// File: src/stsm_pkg.sv
// Package for the seven-tap edge-renormalized smoother.
// Sample width, internal widths and the transaction types shared by the modules.
// No dependencies.
package stsm_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int HIST_DEPTH   = 6;
    localparam int TAPS         = 7;
    localparam int SEEN_W       = 3;
    // weighted sum: up to 22 * 2^(SAMPLE_WIDTH-1) in magnitude
    localparam int SUM_W        = SAMPLE_WIDTH + 5;
    // biased numerator, always positive and below 44 * 2^SAMPLE_WIDTH
    localparam int NP_W         = SAMPLE_WIDTH + 6;
    // reciprocal of twice the divisor, scaled by 2^NP_W; largest is 2^NP_W / 16
    localparam int M_W          = NP_W - 3;
    localparam int PROD_W       = NP_W + M_W;
    localparam int TD_W         = 6;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [1:0]                     t_cnt;

    // One window for the arithmetic pipeline: taps outside the frame are zero.
    typedef struct packed {
        t_sample [TAPS-1:0] tap;
        t_cnt               lcnt;   // taps present left of the center
        t_cnt               rcnt;   // taps present right of the center
        logic               last;
    } t_job;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [3:0]              idx;  // {lcnt, rcnt}
        logic                    last;
    } t_wsum;

    typedef struct packed {
        t_sample smoothed;
        logic    last;
    } t_res;

    function automatic logic signed [SUM_W-1:0] sext_sum(input t_sample x);
        return SUM_W'(x);
    endfunction

endpackage

// File: src/stsm_in_if.sv
// Input channel of the smoother: valid/ready handshake with one sample per transaction.
// Depends on stsm_pkg.
interface stsm_in_if;
    import stsm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// File: src/stsm_out_if.sv
// Output channel of the smoother: valid/ready handshake with one smoothed sample.
// Depends on stsm_pkg.
interface stsm_out_if;
    import stsm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample smoothed;
    logic    last_out;

    modport source (output valid, output smoothed, output last_out, input ready);
    modport sink   (input valid, input smoothed, input last_out, output ready);
endinterface

// File: src/stsm_frame_ctl.sv
// Frame control: sample history, fill count and end-of-frame flush sequencer.
// Issues one registered window per cycle into the arithmetic pipeline while i_en is high.
// Depends on stsm_pkg and stsm_in_if.
module stsm_frame_ctl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stsm_in_if.sink        i_in,
    input  logic           i_en,
    output logic           o_job_valid,
    output stsm_pkg::t_job o_job
);
    import stsm_pkg::*;

    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(HIST_DEPTH);
    localparam logic [SEEN_W-1:0] HALF_WIN  = SEEN_W'(3);
    localparam logic [SEEN_W-1:0] LAST_SLOT = SEEN_W'(HIST_DEPTH);

    t_sample           r_hist [HIST_DEPTH];
    logic [SEEN_W-1:0] r_seen;
    logic              r_flush;
    t_sample           r_cur;
    logic [SEEN_W-1:0] r_c;
    logic [SEEN_W-1:0] r_lo;
    logic              r_job_valid;
    t_job              r_job;

    logic              w_ready;
    logic              w_take;
    logic [SEEN_W-1:0] w_lo_now;
    logic [SEEN_W-1:0] w_first;
    logic [SEEN_W-1:0] w_left;
    t_sample           w_slot [10];
    t_job              w_norm_job;
    t_job              w_flush_job;
    t_job              n_job;
    logic              n_job_valid;

    assign w_ready    = i_en && !r_flush;
    assign w_take     = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    assign w_lo_now = LAST_SLOT - r_seen;
    assign w_first  = (w_lo_now > HALF_WIN) ? w_lo_now : HALF_WIN;
    assign w_left   = r_c - r_lo;

    always_comb begin
        for (int s = 0; s < 10; s++) begin
            w_slot[s] = '0;
        end
        for (int s = 0; s < HIST_DEPTH; s++) begin
            w_slot[s] = r_hist[s];
        end
        w_slot[HIST_DEPTH] = r_cur;

        // steady state: center is the fourth newest sample
        for (int k = 0; k < HIST_DEPTH; k++) begin
            w_norm_job.tap[k] = r_hist[k];
        end
        w_norm_job.tap[TAPS-1] = i_in.sample;
        w_norm_job.lcnt        = 2'(r_seen - HALF_WIN);
        w_norm_job.rcnt        = 2'd3;
        w_norm_job.last        = 1'b0;

        // flush: window slides over the frozen history and the final sample
        for (int k = 0; k < TAPS; k++) begin
            w_flush_job.tap[k] = w_slot[4'(r_c) - 4'd3 + 4'(k)];
        end
        w_flush_job.lcnt = (w_left > HALF_WIN) ? 2'd3 : 2'(w_left);
        w_flush_job.rcnt = 2'(LAST_SLOT - r_c);
        w_flush_job.last = (r_c == LAST_SLOT);

        n_job       = r_flush ? w_flush_job : w_norm_job;
        n_job_valid = r_flush || (w_take && !i_in.last_sample && (r_seen >= HALF_WIN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '{default: '0};
            r_seen      <= '0;
            r_flush     <= 1'b0;
            r_job_valid <= 1'b0;
        end else if (i_en) begin
            r_job_valid <= n_job_valid;
            if (r_flush) begin
                if (r_c == LAST_SLOT) begin
                    // frame done: start the next one from an empty history
                    r_flush <= 1'b0;
                    r_seen  <= '0;
                    r_hist  <= '{default: '0};
                end
            end else if (w_take) begin
                if (i_in.last_sample) begin
                    r_flush <= 1'b1;
                end else begin
                    for (int s = 0; s < HIST_DEPTH - 1; s++) begin
                        r_hist[s] <= r_hist[s+1];
                    end
                    r_hist[HIST_DEPTH-1] <= i_in.sample;
                    if (r_seen != SEEN_FULL) begin
                        r_seen <= r_seen + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job <= n_job;
            if (r_flush) begin
                r_c <= r_c + 1'b1;
            end else if (w_take && i_in.last_sample) begin
                r_cur <= i_in.sample;
                r_lo  <= w_lo_now;
                r_c   <= w_first;
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

`ifndef NO_ASSERTIONS
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_FULL)
        else $error("fill count beyond history depth");

    a_flush_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_c >= r_lo) && (r_c >= HALF_WIN))
        else $error("flush center outside the frame");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flush) |-> (r_seen == '0))
        else $error("history not cleared after flush");
`endif
endmodule

// File: src/stsm_wsum.sv
// Weighted sum stage: 8/4/2/1 kernel over one window, registered.
// Depends on stsm_pkg.
module stsm_wsum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_job_valid,
    input  stsm_pkg::t_job  i_job,
    output logic            o_valid,
    output stsm_pkg::t_wsum o_wsum
);
    import stsm_pkg::*;

    logic  r_valid;
    t_wsum r_wsum;
    t_wsum n_wsum;

    always_comb begin
        n_wsum.sum  = (sext_sum(i_job.tap[3]) <<< 3)
                    + ((sext_sum(i_job.tap[2]) + sext_sum(i_job.tap[4])) <<< 2)
                    + ((sext_sum(i_job.tap[1]) + sext_sum(i_job.tap[5])) <<< 1)
                    + sext_sum(i_job.tap[0]) + sext_sum(i_job.tap[6]);
        n_wsum.idx  = {i_job.lcnt, i_job.rcnt};
        n_wsum.last = i_job.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wsum <= n_wsum;
        end
    end

    assign o_valid = r_valid;
    assign o_wsum  = r_wsum;
endmodule

// File: src/stsm_recip_div.sv
// Rounded division of the weighted sum by the kernel weight total.
// Bias to a positive numerator, multiply by a reciprocal, correct by one.
// Depends on stsm_pkg.
module stsm_recip_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  stsm_pkg::t_wsum i_wsum,
    output logic            o_valid,
    output stsm_pkg::t_res  o_res
);
    import stsm_pkg::*;

    localparam logic [63:0] ONE_SH = 64'd1 << NP_W;

    // twice the weight total, indexed by {left taps, right taps}
    localparam logic [TD_W-1:0] TWOD_TAB [16] = '{
        6'd16, 6'd24, 6'd28, 6'd30,
        6'd24, 6'd32, 6'd36, 6'd38,
        6'd28, 6'd36, 6'd40, 6'd42,
        6'd30, 6'd38, 6'd42, 6'd44
    };

    // floor(2^NP_W / twod); never above the true reciprocal
    localparam logic [M_W-1:0] RECIP_TAB [16] = '{
        M_W'(ONE_SH / 64'd16), M_W'(ONE_SH / 64'd24),
        M_W'(ONE_SH / 64'd28), M_W'(ONE_SH / 64'd30),
        M_W'(ONE_SH / 64'd24), M_W'(ONE_SH / 64'd32),
        M_W'(ONE_SH / 64'd36), M_W'(ONE_SH / 64'd38),
        M_W'(ONE_SH / 64'd28), M_W'(ONE_SH / 64'd36),
        M_W'(ONE_SH / 64'd40), M_W'(ONE_SH / 64'd42),
        M_W'(ONE_SH / 64'd30), M_W'(ONE_SH / 64'd38),
        M_W'(ONE_SH / 64'd42), M_W'(ONE_SH / 64'd44)
    };

    // numerator stage
    logic              r_n_valid;
    logic [NP_W-1:0]   r_np;
    logic [M_W-1:0]    r_m;
    logic [TD_W-1:0]   r_twod;
    logic              r_n_last;
    // product stage
    logic              r_p_valid;
    logic [PROD_W-1:0] r_prod;
    logic [NP_W-1:0]   r_p_np;
    logic [TD_W-1:0]   r_p_twod;
    logic              r_p_last;

    logic [TD_W-1:0]          w_twod;
    logic signed [NP_W:0]     w_bias;
    logic signed [NP_W:0]     w_np_full;
    logic [SAMPLE_WIDTH-1:0]  w_q_est;
    logic [NP_W-1:0]          w_back;
    logic [NP_W-1:0]          w_rem;
    logic [SAMPLE_WIDTH-1:0]  w_q;

    // numerator = 2*sum + d + d*2^SAMPLE_WIDTH, so the quotient carries a
    // bias of 2^(SAMPLE_WIDTH-1) and floor division works on unsigned values
    always_comb begin
        w_twod    = TWOD_TAB[i_wsum.idx];
        w_bias    = $signed(((NP_W+1)'(w_twod) >> 1)
                  + ((NP_W+1)'(w_twod) << (SAMPLE_WIDTH - 1)));
        w_np_full = ($signed((NP_W+1)'($signed(i_wsum.sum))) <<< 1) + w_bias;
    end

    always_comb begin
        w_q_est = r_prod[NP_W +: SAMPLE_WIDTH];
        w_back  = NP_W'(w_q_est) * NP_W'(r_p_twod);
        w_rem   = r_p_np - w_back;
        w_q     = w_q_est + SAMPLE_WIDTH'(w_rem >= NP_W'(r_p_twod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_n_valid <= i_valid;
            r_p_valid <= r_n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np     <= w_np_full[NP_W-1:0];
            r_m      <= RECIP_TAB[i_wsum.idx];
            r_twod   <= w_twod;
            r_n_last <= i_wsum.last;
            r_prod   <= PROD_W'(r_np) * PROD_W'(r_m);
            r_p_np   <= r_np;
            r_p_twod <= r_twod;
            r_p_last <= r_n_last;
        end
    end

    // drop the bias by flipping the sign bit
    assign o_valid        = r_p_valid;
    assign o_res.smoothed = {~w_q[SAMPLE_WIDTH-1], w_q[SAMPLE_WIDTH-2:0]};
    assign o_res.last     = r_p_last;

`ifndef NO_ASSERTIONS
    a_one_step_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (w_rem < (NP_W'(r_p_twod) << 1)))
        else $error("reciprocal estimate off by more than one");
`endif
endmodule

// File: src/stsm_out_buf.sv
// Output register with one skid entry; its fill state stalls the pipeline.
// Depends on stsm_pkg and stsm_out_if.
module stsm_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  stsm_pkg::t_res i_res,
    output logic           o_en,
    stsm_out_if.source     o_out
);
    import stsm_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic w_push;

    assign o_en   = !r_skid_valid;
    assign w_push = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !o_out.ready) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            // hold the stalled result, park the new one
            if (r_out_valid && !o_out.ready) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.smoothed = r_out.smoothed;
    assign o_out.last_out = r_out.last;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");
`endif
endmodule

// File: src/seven_tap_edge_renormalized_smoother.sv
// Seven-tap edge-renormalized smoother, top level.
// Usage:
//   i_in carries one signed sample per transaction, last_sample set on the
//   final sample of a frame. o_out carries the smoothed samples in frame order,
//   last_out set on the final one. Output n is the 8/4/2/1 weighted mean of the
//   samples within three places, divided by the weights present (22 inside the
//   frame, less at the edges), rounded to nearest with ties up.
//   Output n is computed once sample n+3 is taken; the last sample of a frame
//   releases all pending outputs (up to four), one per cycle unless the pipeline
//   holds, and i_in.ready is low until the last of them is issued. Otherwise the
//   input takes one sample per cycle unless the pipeline holds.
//   Path: the transaction that releases a result loads the window register,
//   then the result passes the weighted sum, biased numerator and reciprocal
//   multiply registers, and the correction feeds the output register; flushed
//   results take the same path after the final sample.
//   Reset clears the history and empties the pipeline; the first sample after
//   reset starts a frame. When o_out stalls, one more result lands in a skid
//   entry, then the whole pipeline holds and i_in.ready drops until it drains.
// Depends on stsm_pkg, stsm_in_if, stsm_out_if and the stsm_* stage modules.
module seven_tap_edge_renormalized_smoother (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stsm_in_if.sink    i_in,
    stsm_out_if.source o_out
);
    import stsm_pkg::*;

    logic  w_en;
    logic  w_job_valid;
    t_job  w_job;
    logic  w_sum_valid;
    t_wsum w_wsum;
    logic  w_res_valid;
    t_res  w_res;

    stsm_frame_ctl u_frame_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_en        (w_en),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    stsm_wsum u_wsum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_valid     (w_sum_valid),
        .o_wsum      (w_wsum)
    );

    stsm_recip_div u_recip_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_wsum  (w_wsum),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    stsm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_en    (w_en),
        .o_out   (o_out)
    );
endmodule

// File: tb/seven_tap_edge_renormalized_smoother_tb.sv
// Self-checking testbench for the seven-tap edge-renormalized smoother.
// Sends framed samples with random gaps, keeps a behavioral model of the smoother,
// and checks every smoothed sample in order. Depends on stsm_pkg and both channel interfaces.
module seven_tap_edge_renormalized_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stsm_pkg::*;

    localparam int    QUIET_LIMIT  = 1000;
    localparam int    DRAIN_CYCLES = 20;
    localparam int    HOLD_START   = 100;
    localparam int    HOLD_LEN     = 80;
    localparam int    NOIDLE_LO    = 250;
    localparam int    NOIDLE_HI    = 350;
    localparam int    TARGET_ITEMS = 250;
    localparam t_sample S_MAX      = t_sample'(24'h7FFFFF);
    localparam t_sample S_MIN      = t_sample'(24'h800000);

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_sample_item;

    logic i_clk;
    logic i_rst_n;

    stsm_in_if  in_ch ();
    stsm_out_if out_ch ();

    seven_tap_edge_renormalized_smoother u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_sample_item pending_samples[$];
    t_res         expected_smoothed[$];

    // smoother state as seen by the model
    t_sample hist[HIST_DEPTH];
    int      seen_cnt;

    int  cyc;
    int  quiet_cycles;
    int  mismatches;
    int  n_in;
    int  n_out;
    int  n_frames;
    int  n_queued;
    int  rx_hold_left;
    bit  in_taken;

    function automatic bit idle_allowed();
        return !(cyc >= NOIDLE_LO && cyc < NOIDLE_HI);
    endfunction

    // Weighted mean around slot c; slots outside the frame drop out of the divisor.
    function automatic t_sample weighted_mean(longint win[10], bit ok[10], int c);
        longint acc;
        longint wsum;
        longint num;
        longint den;
        longint q;
        int     s;
        int     span;
        acc  = 0;
        wsum = 0;
        for (int d = -3; d <= 3; d++) begin
            s    = c + d;
            span = (d < 0) ? -d : d;
            if (s >= 0 && s < 10 && ok[s]) begin
                acc  += longint'(8 >> span) * win[s];
                wsum += longint'(8 >> span);
            end
        end
        num = 2 * acc + wsum;
        den = 2 * wsum;
        q   = num / den;
        // round toward minus infinity
        if ((num % den) != 0 && num < 0) q -= 1;
        return t_sample'(q);
    endfunction

    task automatic absorb_sample(t_sample x, logic is_last);
        longint win[10];
        bit     ok[10];
        int     first;
        t_res   r;
        for (int s = 0; s < 10; s++) begin
            win[s] = 0;
            ok[s]  = 0;
        end
        for (int s = 0; s < HIST_DEPTH; s++) begin
            win[s] = longint'(hist[s]);
            ok[s]  = (HIST_DEPTH - s) <= seen_cnt;
        end
        win[6] = longint'(x);
        ok[6]  = 1;
        if (!is_last) begin
            if (ok[3]) begin
                r.smoothed = weighted_mean(win, ok, 3);
                r.last     = 1'b0;
                expected_smoothed.push_back(r);
            end
            for (int s = 0; s < HIST_DEPTH - 1; s++) hist[s] = hist[s + 1];
            hist[HIST_DEPTH - 1] = x;
            if (seen_cnt < HIST_DEPTH) seen_cnt++;
        end else begin
            // flush every output still pending, then start a new frame
            first = 6 - seen_cnt;
            if (first < 3) first = 3;
            for (int s = first; s <= 6; s++) begin
                r.smoothed = weighted_mean(win, ok, s);
                r.last     = (s == 6);
                expected_smoothed.push_back(r);
            end
            for (int s = 0; s < HIST_DEPTH; s++) hist[s] = '0;
            seen_cnt = 0;
        end
    endtask

    task automatic report_mismatch(string msg);
        if (mismatches < 40) $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_sample(t_sample x, logic is_last);
        t_sample_item it;
        it.sample = x;
        it.last   = is_last;
        pending_samples.push_back(it);
        n_queued++;
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return t_sample'(int'($urandom_range(40)) - 20);
            4:       return t_sample'(int'($urandom_range(1000)) - 500);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic push_random_frame();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 15)      len = $urandom_range(3, 1);
        else if (r < 80) len = $urandom_range(12, 4);
        else             len = $urandom_range(30, 13);
        for (int k = 0; k < len; k++) push_sample(rand_sample(), k == len - 1);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: hold the offered sample until taken, then advance or idle.
    always @(negedge i_clk) begin
        t_sample_item nxt;
        if (i_rst_n && !(in_ch.valid && !in_taken)) begin
            if (pending_samples.size() != 0 &&
                !(idle_allowed() && $urandom_range(99) < 17)) begin
                nxt = pending_samples.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.sample      <= nxt.sample;
                in_ch.last_sample <= nxt.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure plus one long hold-off to fill the pipeline.
    always @(negedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (i_rst_n && cyc == HOLD_START) begin
            rx_hold_left = HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !(idle_allowed() && $urandom_range(99) < 17);
        end
    end

    // Monitor: update the model on each input transaction, check each output one.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            cyc      <= cyc + 1;
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                absorb_sample(in_ch.sample, in_ch.last_sample);
                n_in++;
                if (in_ch.last_sample) n_frames++;
            end
            if (out_ch.valid && out_ch.ready) begin
                n_out++;
                if (expected_smoothed.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last %0b",
                                              out_ch.smoothed, out_ch.last_out));
                end else begin
                    want = expected_smoothed.pop_front();
                    if (out_ch.smoothed !== want.smoothed)
                        report_mismatch($sformatf("result %0d: smoothed %0d, want %0d",
                                                  n_out, out_ch.smoothed, want.smoothed));
                    if (out_ch.last_out !== want.last)
                        report_mismatch($sformatf("result %0d: last_out %0b, want %0b",
                                                  n_out, out_ch.last_out, want.last));
                end
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        out_ch.ready      = 1'b0;
        cyc               = 0;
        quiet_cycles      = 0;
        mismatches        = 0;
        n_in              = 0;
        n_out             = 0;
        n_frames          = 0;
        n_queued          = 0;
        rx_hold_left      = 0;
        in_taken          = 1'b0;
        seen_cnt          = 0;
        for (int s = 0; s < HIST_DEPTH; s++) hist[s] = '0;

        // single-sample frames at both extremes
        push_sample(S_MAX, 1'b1);
        push_sample(S_MIN, 1'b1);
        // two- and three-sample frames
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        push_sample(t_sample'(1), 1'b0);
        push_sample(t_sample'(0), 1'b0);
        push_sample(t_sample'(-1), 1'b1);
        // four samples: last one releases all four outputs
        for (int k = 0; k < 4; k++) push_sample(S_MAX, k == 3);
        // seven samples alternating extremes
        for (int k = 0; k < 7; k++) push_sample((k % 2) ? S_MIN : S_MAX, k == 6);
        // small values to exercise rounding ties around zero
        push_sample(t_sample'(-1), 1'b0);
        push_sample(t_sample'(0), 1'b0);
        push_sample(t_sample'(1), 1'b0);
        push_sample(t_sample'(-1), 1'b0);
        push_sample(t_sample'(1), 1'b0);
        push_sample(t_sample'(0), 1'b1);

        while (n_queued < TARGET_ITEMS) push_random_frame();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_smoothed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_smoothed.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_smoothed.size()));
        $display("run covered %0d frames: %0d samples sent, %0d smoothed samples checked",
                 n_frames, n_in, n_out);
        $display("%0d mismatches, one long output hold-off included", mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
